[sv/mma_pkg.sv]
// Package: types, sizes and control structs of the multichannel moving average.
`timescale 1ns / 1ps
`default_nettype none
package mma_pkg;

	localparam int WINDOW       = 10;
	localparam int CHANNELS     = 8;
	localparam int SAMPLE_WIDTH = 16;

	localparam int CH_FIELD_W   = 3;
	localparam int FILL_FIELD_W = 4;

	localparam int CH_IDX_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
	localparam int SLOT_W   = (WINDOW > 1) ? $clog2(WINDOW) : 1;
	localparam int FILL_W   = $clog2(WINDOW + 1);
	localparam int SUM_W    = SAMPLE_WIDTH + FILL_W;
	localparam int DEPTH    = CHANNELS * WINDOW;
	localparam int ADDR_W   = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	// reciprocal scale: exact floor(a/d) for a < 2**SUM_W, d < 2**FILL_W
	localparam int RECIP_K = SUM_W + FILL_W;
	localparam int RECIP_W = RECIP_K + 1;
	localparam int PROD_W  = SUM_W + RECIP_W;

	typedef struct packed {
		logic [CH_FIELD_W-1:0]          channel;
		logic signed [SAMPLE_WIDTH-1:0] sample;
	} sample_t;

	typedef struct packed {
		logic [CH_FIELD_W-1:0]          out_channel;
		logic signed [SAMPLE_WIDTH-1:0] average;
		logic [FILL_FIELD_W-1:0]        fill_count;
	} result_t;

	typedef struct packed {
		logic capture;
		logic update;
		logic mul;
		logic out_load;
	} mma_cmd_t;

	typedef struct packed {
		logic out_free;
	} mma_sts_t;

endpackage
`default_nettype wire

[sv/mma_ctrl.sv]
// Controller: sequences one item through capture, update, multiply and output.
`timescale 1ns / 1ps
`default_nettype none
module mma_ctrl
	import mma_pkg::*;
(
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire logic     sample_valid,
	output logic          sample_stall,
	input  wire mma_sts_t sts,
	output mma_cmd_t      cmd
);

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_UPD  = 2'd1;
	localparam logic [1:0] ST_MUL  = 2'd2;
	localparam logic [1:0] ST_OUT  = 2'd3;

	logic [1:0] state_q;
	logic [1:0] state_d;

	assign sample_stall = (state_q != ST_IDLE);

	always_comb begin
		state_d      = state_q;
		cmd          = '0;
		case (state_q)
			ST_IDLE: begin
				if (sample_valid) begin
					cmd.capture = 1'b1;
					state_d     = ST_UPD;
				end
			end
			ST_UPD: begin
				cmd.update = 1'b1;
				state_d    = ST_MUL;
			end
			ST_MUL: begin
				cmd.mul = 1'b1;
				state_d = ST_OUT;
			end
			ST_OUT: begin
				// hold until the output register can take the item
				if (sts.out_free) begin
					cmd.out_load = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule
`default_nettype wire

[sv/mma_datapath.sv]
// Datapath: per-channel state, sample ring memory, reciprocal divide, output register.
`timescale 1ns / 1ps
`default_nettype none
module mma_datapath
	import mma_pkg::*;
(
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire sample_t  sample_data,
	input  wire mma_cmd_t cmd,
	output mma_sts_t      sts,
	output logic          result_valid,
	input  wire logic     result_stall,
	output result_t       result_data
);

	localparam int RTAB_N = 2 ** FILL_W;

	// per-channel state
	logic [SLOT_W-1:0]       slot_q [CHANNELS];
	logic [FILL_W-1:0]       fill_q [CHANNELS];
	logic signed [SUM_W-1:0] sum_q  [CHANNELS];

	// ring memory, no reset: an entry's read value is used only after it was written
	logic [SAMPLE_WIDTH-1:0] mem [DEPTH];

	logic [RECIP_W-1:0] recip_tab [RTAB_N];

	for (genvar d = 0; d < RTAB_N; d++) begin : g_recip
		localparam int          DIV   = (d == 0) ? 1 : d;
		localparam logic [63:0] ONE_K = 64'd1 << RECIP_K;
		localparam logic [63:0] RVAL  = (d >= 1 && d <= WINDOW) ?
			(ONE_K + 64'(DIV) - 64'd1) / 64'(DIV) : 64'd0;
		assign recip_tab[d] = RVAL[RECIP_W-1:0];
	end

	logic [CH_IDX_W-1:0] idx_in;
	logic [ADDR_W-1:0]   addr_in;
	logic                range_in;

	assign idx_in   = CH_IDX_W'(sample_data.channel);
	assign range_in = (int'(sample_data.channel) < CHANNELS);
	assign addr_in  = ADDR_W'(int'(idx_in) * WINDOW) + ADDR_W'(slot_q[idx_in]);

	// stage 1: captured item and its channel state
	logic [CH_FIELD_W-1:0]          ch_s1;
	logic [CH_IDX_W-1:0]            idx_s1;
	logic                           range_s1;
	logic signed [SAMPLE_WIDTH-1:0] smp_s1;
	logic [SLOT_W-1:0]              slot_s1;
	logic [FILL_W-1:0]              fill_s1;
	logic signed [SUM_W-1:0]        sum_s1;
	logic [ADDR_W-1:0]              addr_s1;
	logic [SAMPLE_WIDTH-1:0]        rd_s1;

	// stage 2: updated sum as sign and magnitude
	logic [FILL_W-1:0] fill_s2;
	logic              neg_s2;
	logic [SUM_W-1:0]  abs_s2;

	// stage 3: scaled product
	logic [PROD_W-1:0] prod_s3;

	logic                    full;
	logic [FILL_W-1:0]       fill_new;
	logic signed [SUM_W-1:0] old_ext;
	logic signed [SUM_W-1:0] sum_new;
	logic [SLOT_W-1:0]       slot_new;

	assign full     = (fill_s1 >= FILL_W'(WINDOW));
	assign fill_new = full ? fill_s1 : FILL_W'(fill_s1 + 1'b1);
	assign old_ext  = full ? SUM_W'($signed(rd_s1)) : '0;
	assign sum_new  = sum_s1 - old_ext + SUM_W'(smp_s1);
	assign slot_new = (slot_s1 == SLOT_W'(WINDOW - 1)) ? '0 : SLOT_W'(slot_s1 + 1'b1);

	logic [SUM_W-1:0]        quot;
	logic [SUM_W-1:0]        quot_signed;
	logic signed [SAMPLE_WIDTH-1:0] avg;

	assign quot        = prod_s3[RECIP_K +: SUM_W];
	assign quot_signed = neg_s2 ? SUM_W'(-quot) : quot;
	assign avg         = range_s1 ? $signed(quot_signed[SAMPLE_WIDTH-1:0]) : '0;

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			ch_s1    <= sample_data.channel;
			idx_s1   <= idx_in;
			range_s1 <= range_in;
			smp_s1   <= sample_data.sample;
			slot_s1  <= slot_q[idx_in];
			fill_s1  <= fill_q[idx_in];
			sum_s1   <= sum_q[idx_in];
			addr_s1  <= addr_in;
			rd_s1    <= mem[addr_in];
		end
		if (cmd.update) begin
			fill_s2 <= fill_new;
			neg_s2  <= sum_new[SUM_W-1];
			abs_s2  <= sum_new[SUM_W-1] ? SUM_W'(-sum_new) : SUM_W'(sum_new);
		end
		if (cmd.mul) begin
			prod_s3 <= PROD_W'(abs_s2) * PROD_W'(recip_tab[fill_s2]);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.update && range_s1) begin
			mem[addr_s1] <= smp_s1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int c = 0; c < CHANNELS; c++) begin
				slot_q[c] <= '0;
				fill_q[c] <= '0;
				sum_q[c]  <= '0;
			end
		end else if (cmd.update && range_s1) begin
			slot_q[idx_s1] <= slot_new;
			fill_q[idx_s1] <= fill_new;
			sum_q[idx_s1]  <= sum_new;
		end
	end

	// output register parts the result side from the sequencer
	logic    res_valid_q;
	result_t res_q;

	assign sts.out_free = !res_valid_q || !result_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (cmd.out_load) begin
			res_valid_q <= 1'b1;
		end else if (!result_stall) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			res_q.out_channel <= ch_s1;
			res_q.average     <= avg;
			res_q.fill_count  <= range_s1 ? FILL_FIELD_W'(fill_s2) : '0;
		end
	end

	assign result_valid = res_valid_q;
	assign result_data  = res_q;

endmodule
`default_nettype wire

[sv/multichannel_moving_average.sv]
// Top level: per-channel moving average over the last WINDOW samples.
//
//   channel   direction  handshake                    payload
//   sample    receive    sample_valid / sample_stall  sample_data (channel, sample)
//   result    send       result_valid / result_stall  result_data (out_channel, average,
//                                                     fill_count)
//
// An item passes from acceptance through capture with ring read, sum update with
// ring write, reciprocal multiply and an output load that waits on a stalled full
// output register; a new item is taken only after the current one is loaded there.
// A result that waits in the output register does not block the next item until
// that item's own result is ready. Reset clears fill counts, slots and sums at once.
`timescale 1ns / 1ps
`default_nettype none
module multichannel_moving_average
	import mma_pkg::*;
(
	input  wire logic    clk,
	input  wire logic    arst_n,
	input  wire logic    sample_valid,
	output logic         sample_stall,
	input  wire sample_t sample_data,
	output logic         result_valid,
	input  wire logic    result_stall,
	output result_t      result_data
);

	mma_cmd_t cmd;
	mma_sts_t sts;

	mma_ctrl u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.sample_valid (sample_valid),
		.sample_stall (sample_stall),
		.sts          (sts),
		.cmd          (cmd)
	);

	mma_datapath u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.sample_data  (sample_data),
		.cmd          (cmd),
		.sts          (sts),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result_data  (result_data)
	);

endmodule
`default_nettype wire
